/* rtl/hht_pkg.sv */
// hht_pkg: shared types and constants of the header tokenizer
// transaction payloads, result bundle, result kind codes and config map
// no dependencies
`timescale 1ns / 1ps

package hht_pkg;

    localparam int HHT_QUEUE_DEPTH = 4;
    localparam int HHT_MAX_RESULTS = 3;
    localparam int HHT_PADDR_W     = 3;
    localparam int HHT_PDATA_W     = 32;

    // register index taken from paddr above the byte offset
    localparam logic REG_FIRST_LINE_SPLITS_AT_SPACE = 1'b0;

    localparam logic [2:0] K_NAME  = 3'd0;
    localparam logic [2:0] K_VALUE = 3'd1;
    localparam logic [2:0] K_EOL   = 3'd2;
    localparam logic [2:0] K_NOSEP = 3'd3;
    localparam logic [2:0] K_HEND  = 3'd4;
    localparam logic [2:0] K_BODY  = 3'd5;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_message;
    } t_hht_in;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_byte;
        logic       last;
    } t_hht_out;

    // all results caused by one input byte, count is 1 to 3
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][2:0] kinds;
        logic [2:0][7:0] bytes;
    } t_hht_bundle;

endpackage

/* rtl/hht_front.sv */
// hht_front: accepts input bytes and runs the line parser state machine
// produces one bundle of results per accepted byte that yields any results, pushed into the queue
// depends on hht_pkg
`timescale 1ns / 1ps

module hht_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_splits_at_space,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hht_pkg::t_hht_in    i_in_item,
    input  logic                i_q_full,
    output logic                o_push,
    output hht_pkg::t_hht_bundle o_bundle
);
    import hht_pkg::*;

    localparam logic [2:0] PH_START    = 3'd0;
    localparam logic [2:0] PH_NAME     = 3'd1;
    localparam logic [2:0] PH_VLEAD    = 3'd2;
    localparam logic [2:0] PH_VALUE    = 3'd3;
    localparam logic [2:0] PH_SKIP     = 3'd5;
    localparam logic [2:0] PH_ENDBLANK = 3'd6;
    localparam logic [2:0] PH_BODY     = 3'd7;

    typedef struct packed {
        logic [2:0] phase;
        logic       header_seen;
        logic       cr_in_line;
        logic       lf_pending;
        logic       separator_found;
    } t_hht_state;

    typedef struct packed {
        t_hht_state  st;
        t_hht_bundle res;
    } t_hht_ctx;

    localparam t_hht_state STATE_RESET = '{PH_START, 1'b0, 1'b0, 1'b0, 1'b0};

    function automatic t_hht_ctx f_put(t_hht_ctx c, logic [2:0] k, logic [7:0] b);
        t_hht_ctx r;
        r = c;
        if (c.res.count != 2'd3) begin
            r.res.kinds[c.res.count] = k;
            r.res.bytes[c.res.count] = b;
            r.res.count = c.res.count + 2'd1;
        end
        return r;
    endfunction

    function automatic t_hht_ctx f_content(t_hht_ctx c, logic [7:0] b, logic splits);
        t_hht_ctx   r;
        logic [7:0] sep;
        r   = c;
        sep = (!c.st.header_seen && splits) ? CH_SP : CH_COLON;
        if (c.st.phase == PH_NAME) begin
            if (b == sep) begin
                r.st.separator_found = 1'b1;
                r.st.phase = PH_VLEAD;
            end else begin
                r = f_put(r, K_NAME, b);
            end
        end else if (c.st.phase == PH_VLEAD) begin
            if (b != CH_SP && b != CH_HT) begin
                r.st.phase = PH_VALUE;
                r = f_put(r, K_VALUE, b);
            end
        end else begin
            r = f_put(r, K_VALUE, b);
        end
        return r;
    endfunction

    function automatic t_hht_ctx f_line_end(t_hht_ctx c);
        t_hht_ctx r;
        r = f_put(c, c.st.separator_found ? K_EOL : K_NOSEP, 8'd0);
        r.st.header_seen     = 1'b1;
        r.st.phase           = PH_START;
        r.st.cr_in_line      = 1'b0;
        r.st.lf_pending      = 1'b0;
        r.st.separator_found = 1'b0;
        return r;
    endfunction

    function automatic t_hht_ctx f_line_start(t_hht_ctx c, logic [7:0] b, logic splits);
        t_hht_ctx r;
        r = c;
        if (b == CH_CR || b == CH_LF) begin
            if (c.st.header_seen) begin
                r = f_put(r, K_HEND, 8'd0);
                r.st.phase = (b == CH_LF) ? PH_BODY : PH_ENDBLANK;
            end else begin
                r.st.phase = (b == CH_LF) ? PH_START : PH_SKIP;
            end
        end else begin
            r.st.phase = PH_NAME;
            r = f_content(r, b, splits);
        end
        return r;
    endfunction

    t_hht_state r_state;
    t_hht_state n_state;
    t_hht_ctx   ctx;
    logic [7:0] b;
    logic       accept;

    assign b          = i_in_item.data_byte;
    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        ctx.st  = i_in_item.new_message ? STATE_RESET : r_state;
        ctx.res = '0;
        case (ctx.st.phase)
            PH_START: begin
                ctx = f_line_start(ctx, b, i_splits_at_space);
            end
            PH_SKIP: begin
                if (b == CH_LF) ctx.st.phase = PH_START;
            end
            PH_ENDBLANK: begin
                if (b == CH_LF) ctx.st.phase = PH_BODY;
            end
            PH_BODY: begin
                ctx = f_put(ctx, K_BODY, b);
            end
            PH_NAME, PH_VLEAD, PH_VALUE: begin
                if (ctx.st.lf_pending) begin
                    if (b == CH_SP || b == CH_HT) begin
                        // folded line
                        if (ctx.st.cr_in_line) ctx = f_content(ctx, CH_SP, i_splits_at_space);
                        ctx = f_content(ctx, CH_SP, i_splits_at_space);
                        ctx = f_content(ctx, b, i_splits_at_space);
                        ctx.st.cr_in_line = 1'b0;
                        ctx.st.lf_pending = 1'b0;
                    end else begin
                        ctx = f_line_end(ctx);
                        ctx = f_line_start(ctx, b, i_splits_at_space);
                    end
                end else if (b == CH_LF) begin
                    if (ctx.st.header_seen) ctx.st.lf_pending = 1'b1;
                    else ctx = f_line_end(ctx);
                end else if (ctx.st.cr_in_line) begin
                    ctx = ctx;
                end else if (b == CH_CR) begin
                    ctx.st.cr_in_line = 1'b1;
                end else begin
                    ctx = f_content(ctx, b, i_splits_at_space);
                end
            end
            default: begin
                ctx.st.phase = PH_START;
            end
        endcase
    end

    assign n_state  = accept ? ctx.st : r_state;
    assign o_push   = accept && (ctx.res.count != 2'd0);
    assign o_bundle = ctx.res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/hht_queue.sv */
// hht_queue: small fifo of result bundles between parser and output stage
// depends on hht_pkg
`timescale 1ns / 1ps

module hht_queue #(
    parameter int Depth = hht_pkg::HHT_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  hht_pkg::t_hht_bundle i_push_data,
    output logic                 o_full,
    output logic                 o_head_valid,
    output hht_pkg::t_hht_bundle o_head,
    input  logic                 i_pop
);
    import hht_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    t_hht_bundle     r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [PtrW-1:0] n_rd_ptr;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] n_count;
    logic            push_en;
    logic            pop_en;

    assign o_full       = (r_count == FullCnt);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign push_en      = i_push && !o_full;
    assign pop_en       = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_en) n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        if (pop_en)  n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        if (push_en && !pop_en)      n_count = r_count + 1'b1;
        else if (!push_en && pop_en) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (push_en) r_mem[r_wr_ptr] <= i_push_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FullCnt)
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_en && !pop_en) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

/* rtl/hht_back.sv */
// hht_back: walks the head bundle one result per cycle, while the output is ready, into the output register
// depends on hht_pkg
`timescale 1ns / 1ps

module hht_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_head_valid,
    input  hht_pkg::t_hht_bundle i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output hht_pkg::t_hht_out    o_out_item
);
    import hht_pkg::*;

    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic       r_out_valid;
    logic       n_out_valid;
    t_hht_out   r_out;
    t_hht_out   n_out;
    logic       load;
    logic       at_last;

    assign load    = i_head_valid && (!r_out_valid || i_out_ready);
    assign at_last = (r_idx == (i_head.count - 2'd1));
    assign o_pop   = load && at_last;

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (load) begin
            n_out_valid    = 1'b1;
            n_out.kind     = i_head.kinds[r_idx];
            n_out.out_byte = i_head.bytes[r_idx];
            n_out.last     = at_last;
            n_idx          = at_last ? 2'd0 : r_idx + 2'd1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_idx_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> (r_idx < i_head.count))
        else $error("result index beyond bundle");

endmodule

/* rtl/http_header_tokenizer_core.sv */
// http_header_tokenizer_core: top level of the header line tokenizer
// path: an accepted byte's results are written into the queue, then loaded into the output register
// throughput: one byte per cycle in while the queue is not full, one result per cycle out while
// the output is ready; input stalls only while the queue is full
// reset: parser state cleared, queue and output emptied, first_line_splits_at_space = 1
// instantiates hht_front, hht_queue, hht_back; depends on hht_pkg
`timescale 1ns / 1ps

module http_header_tokenizer_core #(
    parameter int QueueDepth = hht_pkg::HHT_QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hht_pkg::HHT_PADDR_W-1:0]   paddr,
    input  logic [hht_pkg::HHT_PDATA_W-1:0]   pwdata,
    output logic [hht_pkg::HHT_PDATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  hht_pkg::t_hht_in                  i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output hht_pkg::t_hht_out                 o_out_item
);
    import hht_pkg::*;

    logic        r_splits;
    logic        n_splits;
    logic        cfg_wr;
    logic        reg_hit;
    logic        q_full;
    logic        push;
    t_hht_bundle push_data;
    logic        head_valid;
    t_hht_bundle head;
    logic        pop;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[HHT_PADDR_W-1] == REG_FIRST_LINE_SPLITS_AT_SPACE);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign n_splits = (cfg_wr && reg_hit) ? pwdata[0] : r_splits;
    assign prdata  = reg_hit ? {{(HHT_PDATA_W-1){1'b0}}, r_splits} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_splits <= 1'b1;
        end else begin
            r_splits <= n_splits;
        end
    end

    hht_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_splits_at_space (r_splits),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_in_item         (i_in_item),
        .i_q_full          (q_full),
        .o_push            (push),
        .o_bundle          (push_data)
    );

    hht_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (push_data),
        .o_full       (q_full),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    hht_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule

/* tb/tb_http_header_tokenizer_core.sv */
// tb_http_header_tokenizer_core: self-checking bench for the header line tokenizer
// directed byte table, then random header blocks and noise under both first-line modes
// depends on hht_pkg and http_header_tokenizer_core
`timescale 1ns / 1ps

module tb_http_header_tokenizer_core;

    import hht_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RAND_ITEMS     = 65;
    localparam int DIR_ROWS       = 28;

    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_NAME     = 3'd1,
        PH_VLEAD    = 3'd2,
        PH_VALUE    = 3'd3,
        PH_SKIP     = 3'd5,
        PH_ENDBLANK = 3'd6,
        PH_BODY     = 3'd7
    } t_tok_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_message;
        logic       fixed_exp;
        logic [1:0] n_exp;
        logic [2:0] kind0;
        logic [7:0] byte0;
        logic [2:0] kind1;
        logic [7:0] byte1;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [HHT_PADDR_W-1:0] paddr = '0;
    logic [HHT_PDATA_W-1:0] pwdata = '0;
    logic [HHT_PDATA_W-1:0] prdata;
    logic                   pready;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    t_hht_in                i_in_item = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_hht_out               o_out_item;

    // predictor state
    t_tok_phase tok_phase = PH_START;
    logic       tok_header_seen = 1'b0;
    logic       tok_cr_in_line = 1'b0;
    logic       tok_lf_pending = 1'b0;
    logic       tok_sep_found = 1'b0;
    logic       split_at_space = 1'b1;

    t_hht_out   byte_tokens[$];
    t_hht_out   typed_tokens[$];
    t_hht_out   expected_tokens[$];
    logic [7:0] msg_bytes[$];
    t_dir_row   dir_table [DIR_ROWS];

    bit no_idle = 1'b0;
    int n_items = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_messages = 0;
    int n_cfg_writes = 0;
    int ready_wait = 0;
    int quiet_cycles = 0;

    http_header_tokenizer_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function void emit(input logic [2:0] k, input logic [7:0] b);
        t_hht_out r;
        if (byte_tokens.size() < HHT_MAX_RESULTS) begin
            r.kind     = k;
            r.out_byte = b;
            r.last     = 1'b0;
            byte_tokens.push_back(r);
        end
    endfunction

    function void line_content(input logic [7:0] b);
        logic [7:0] sep;
        if (tok_phase == PH_NAME) begin
            sep = (!tok_header_seen && split_at_space) ? CH_SP : CH_COLON;
            if (b == sep) begin
                tok_sep_found = 1'b1;
                tok_phase     = PH_VLEAD;
            end else begin
                emit(K_NAME, b);
            end
        end else if (tok_phase == PH_VLEAD) begin
            if (b != CH_SP && b != CH_HT) begin
                tok_phase = PH_VALUE;
                emit(K_VALUE, b);
            end
        end else begin
            emit(K_VALUE, b);
        end
    endfunction

    function void close_line();
        emit(tok_sep_found ? K_EOL : K_NOSEP, 8'h00);
        tok_header_seen = 1'b1;
        tok_phase       = PH_START;
        tok_cr_in_line  = 1'b0;
        tok_lf_pending  = 1'b0;
        tok_sep_found   = 1'b0;
    endfunction

    function void open_line(input logic [7:0] b);
        if (b == CH_CR || b == CH_LF) begin
            if (tok_header_seen) begin
                emit(K_HEND, 8'h00);
                if (b == CH_LF) begin
                    tok_phase = PH_BODY;
                end else begin
                    tok_phase = PH_ENDBLANK;
                end
            end else if (b == CH_LF) begin
                tok_phase = PH_START;
            end else begin
                tok_phase = PH_SKIP;
            end
        end else begin
            tok_phase = PH_NAME;
            line_content(b);
        end
    endfunction

    function void tokenize_byte(input t_hht_in item);
        logic [7:0] b;
        t_hht_out   r;
        b = item.data_byte;
        byte_tokens.delete();
        if (item.new_message) begin
            tok_phase       = PH_START;
            tok_header_seen = 1'b0;
            tok_cr_in_line  = 1'b0;
            tok_lf_pending  = 1'b0;
            tok_sep_found   = 1'b0;
        end
        case (tok_phase)
            PH_START: begin
                open_line(b);
            end
            PH_SKIP: begin
                if (b == CH_LF) tok_phase = PH_START;
            end
            PH_ENDBLANK: begin
                if (b == CH_LF) tok_phase = PH_BODY;
            end
            PH_BODY: begin
                emit(K_BODY, b);
            end
            PH_NAME, PH_VLEAD, PH_VALUE: begin
                if (tok_lf_pending) begin
                    if (b == CH_SP || b == CH_HT) begin
                        if (tok_cr_in_line) line_content(CH_SP);
                        line_content(CH_SP);
                        line_content(b);
                        tok_cr_in_line = 1'b0;
                        tok_lf_pending = 1'b0;
                    end else begin
                        close_line();
                        open_line(b);
                    end
                end else if (b == CH_LF) begin
                    if (tok_header_seen) begin
                        tok_lf_pending = 1'b1;
                    end else begin
                        close_line();
                    end
                end else if (tok_cr_in_line) begin
                    // dropped until lf
                end else if (b == CH_CR) begin
                    tok_cr_in_line = 1'b1;
                end else begin
                    line_content(b);
                end
            end
            default: begin
                tok_phase = PH_START;
            end
        endcase
        if (byte_tokens.size() != 0) begin
            r      = byte_tokens.pop_back();
            r.last = 1'b1;
            byte_tokens.push_back(r);
        end
    endfunction

    function t_dir_row free_row(input logic [7:0] b, input logic nm);
        t_dir_row row;
        row             = '0;
        row.data_byte   = b;
        row.new_message = nm;
        return row;
    endfunction

    function t_dir_row fixed_row(input logic [7:0] b, input logic nm, input logic [1:0] n,
                                 input logic [2:0] k0, input logic [7:0] d0,
                                 input logic [2:0] k1, input logic [7:0] d1);
        t_dir_row row;
        row           = free_row(b, nm);
        row.fixed_exp = 1'b1;
        row.n_exp     = n;
        row.kind0     = k0;
        row.byte0     = d0;
        row.kind1     = k1;
        row.byte1     = d1;
        return row;
    endfunction

    function logic [7:0] text_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == CH_LF || b == CH_CR || b == CH_SP || b == CH_HT || b == CH_COLON);
        return b;
    endfunction

    function logic [7:0] noisy_byte();
        case ($urandom_range(0, 9))
            0: return CH_LF;
            1: return CH_CR;
            2: return CH_SP;
            3: return CH_HT;
            4: return CH_COLON;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function logic [7:0] blank_byte();
        return ($urandom_range(0, 1) == 0) ? CH_SP : CH_HT;
    endfunction

    function void push_text(input int max_len);
        repeat ($urandom_range(0, max_len)) msg_bytes.push_back(text_byte());
    endfunction

    function void push_line_end();
        if ($urandom_range(0, 2) == 0) begin
            msg_bytes.push_back(CH_LF);
        end else begin
            msg_bytes.push_back(CH_CR);
            if ($urandom_range(0, 4) == 0) msg_bytes.push_back(noisy_byte() | 8'h40);
            msg_bytes.push_back(CH_LF);
        end
    endfunction

    function void build_message();
        msg_bytes.delete();
        repeat ($urandom_range(0, 2)) push_line_end();
        // request or status line
        msg_bytes.push_back(text_byte());
        push_text(4);
        if (($urandom_range(0, 4) == 0) ^ split_at_space) begin
            msg_bytes.push_back(CH_SP);
        end else begin
            msg_bytes.push_back(CH_COLON);
        end
        repeat ($urandom_range(0, 2)) msg_bytes.push_back(CH_SP);
        push_text(6);
        push_line_end();
        repeat ($urandom_range(0, 4)) begin
            msg_bytes.push_back(text_byte());
            push_text(5);
            if ($urandom_range(0, 7) != 0) msg_bytes.push_back(CH_COLON);
            repeat ($urandom_range(0, 2)) msg_bytes.push_back(blank_byte());
            push_text(6);
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    msg_bytes.push_back(CH_CR);
                    if ($urandom_range(0, 2) == 0) msg_bytes.push_back(noisy_byte() | 8'h40);
                end
                msg_bytes.push_back(CH_LF);
                msg_bytes.push_back(blank_byte());
                push_text(4);
            end
            push_line_end();
        end
        push_line_end();
        repeat ($urandom_range(0, 5)) msg_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    task send_byte(input t_hht_in item, input bit use_typed);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        n_items++;
        tokenize_byte(item);
        if (use_typed) begin
            for (int i = 0; i < typed_tokens.size(); i++) expected_tokens.push_back(typed_tokens[i]);
        end else begin
            for (int i = 0; i < byte_tokens.size(); i++) expected_tokens.push_back(byte_tokens[i]);
        end
    endtask

    task wait_idle();
        i_in_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task cfg_write(input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_FIRST_LINE_SPLITS_AT_SPACE, 2'b00};
        pwdata  <= HHT_PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        split_at_space = value;
        n_cfg_writes++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_hht_out want;
        int       w;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            ready_wait  <= 0;
        end else if (o_out_valid && i_out_ready) begin
            n_results++;
            if (expected_tokens.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, expected none, actual kind=%0d byte=%02h last=%0d",
                         $time, o_out_item.kind, o_out_item.out_byte, o_out_item.last);
            end else begin
                want = expected_tokens.pop_front();
                if (o_out_item.kind !== want.kind) begin
                    n_errors++;
                    $display("%0t: kind mismatch, expected %0d actual %0d",
                             $time, want.kind, o_out_item.kind);
                end
                if (o_out_item.out_byte !== want.out_byte) begin
                    n_errors++;
                    $display("%0t: out_byte mismatch, expected %02h actual %02h",
                             $time, want.out_byte, o_out_item.out_byte);
                end
                if (o_out_item.last !== want.last) begin
                    n_errors++;
                    $display("%0t: last mismatch, expected %0d actual %0d",
                             $time, want.last, o_out_item.last);
                end
            end
            w = no_idle ? 0 : $urandom_range(0, 6);
            if (w == 0) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                ready_wait  <= w;
            end
        end else if (ready_wait > 1) begin
            ready_wait <= ready_wait - 1;
        end else begin
            ready_wait  <= 0;
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_hht_in  item;
        t_hht_out r;
        t_dir_row row;
        int       sent;
        bit       is_msg;

        // blank lines before the first line are skipped
        dir_table[0]  = fixed_row(CH_LF, 1'b1, 2'd0, K_NAME, 8'h00, K_NAME, 8'h00);
        dir_table[1]  = fixed_row(CH_CR, 1'b0, 2'd0, K_NAME, 8'h00, K_NAME, 8'h00);
        dir_table[2]  = fixed_row(CH_LF, 1'b0, 2'd0, K_NAME, 8'h00, K_NAME, 8'h00);
        // request line split at space, leading blanks of the value dropped
        dir_table[3]  = free_row(8'h47, 1'b0);
        dir_table[4]  = free_row(CH_SP, 1'b0);
        dir_table[5]  = free_row(CH_HT, 1'b0);
        dir_table[6]  = free_row(8'h2F, 1'b0);
        dir_table[7]  = fixed_row(8'h00, 1'b0, 2'd1, K_VALUE, 8'h00, K_NAME, 8'h00);
        dir_table[8]  = free_row(CH_CR, 1'b0);
        dir_table[9]  = fixed_row(CH_LF, 1'b0, 2'd1, K_EOL, 8'h00, K_NAME, 8'h00);
        // header line with an lf fold inside the name
        dir_table[10] = free_row(8'h48, 1'b0);
        dir_table[11] = fixed_row(8'hFF, 1'b0, 2'd1, K_NAME, 8'hFF, K_NAME, 8'h00);
        dir_table[12] = free_row(CH_LF, 1'b0);
        dir_table[13] = free_row(CH_HT, 1'b0);
        dir_table[14] = free_row(CH_COLON, 1'b0);
        dir_table[15] = free_row(8'h76, 1'b0);
        // crlf fold with a dropped byte after cr
        dir_table[16] = free_row(CH_CR, 1'b0);
        dir_table[17] = free_row(8'h78, 1'b0);
        dir_table[18] = free_row(CH_LF, 1'b0);
        dir_table[19] = free_row(CH_SP, 1'b0);
        // deferred line end, then a line without separator
        dir_table[20] = free_row(CH_CR, 1'b0);
        dir_table[21] = free_row(CH_LF, 1'b0);
        dir_table[22] = free_row(8'h4E, 1'b0);
        dir_table[23] = free_row(CH_LF, 1'b0);
        // blank line starting with cr ends the headers
        dir_table[24] = fixed_row(CH_CR, 1'b0, 2'd2, K_NOSEP, 8'h00, K_HEND, 8'h00);
        dir_table[25] = free_row(8'h7A, 1'b0);
        dir_table[26] = free_row(CH_LF, 1'b0);
        dir_table[27] = fixed_row(8'h80, 1'b0, 2'd1, K_BODY, 8'h80, K_NAME, 8'h00);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = dir_table[i];
            typed_tokens.delete();
            for (int j = 0; j < row.n_exp; j++) begin
                r.kind     = (j == 0) ? row.kind0 : row.kind1;
                r.out_byte = (j == 0) ? row.byte0 : row.byte1;
                r.last     = (j == row.n_exp - 1);
                typed_tokens.push_back(r);
            end
            item.data_byte   = row.data_byte;
            item.new_message = row.new_message;
            send_byte(item, row.fixed_exp);
        end
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            cfg_write((ph % 2) == 1);
            sent = 0;
            while (sent < RAND_ITEMS) begin
                no_idle = ($urandom_range(0, 4) == 0);
                is_msg  = ($urandom_range(0, 4) != 0);
                if (is_msg) begin
                    build_message();
                    n_messages++;
                end else begin
                    msg_bytes.delete();
                    repeat ($urandom_range(1, 8)) msg_bytes.push_back(noisy_byte());
                end
                for (int i = 0; i < msg_bytes.size(); i++) begin
                    item.data_byte   = msg_bytes[i];
                    item.new_message = (is_msg && i == 0) || ($urandom_range(0, 39) == 0);
                    send_byte(item, 1'b0);
                end
                sent += msg_bytes.size();
                if ($urandom_range(0, 5) == 0) wait_idle();
            end
            no_idle = 1'b0;
            wait_idle();
        end

        $display("covered %0d input bytes, %0d results, %0d random messages plus noise",
                 n_items, n_results, n_messages);
        $display("first line split at space and at colon over %0d register writes",
                 n_cfg_writes);
        if (n_errors == 0 && expected_tokens.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/hht_pkg.sv
rtl/hht_front.sv
rtl/hht_queue.sv
rtl/hht_back.sv
rtl/http_header_tokenizer_core.sv
tb/tb_http_header_tokenizer_core.sv
